@@ src/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants
// quaternion to yaw-pitch-roll converter, fixed point formats and tables
// ----------------------------------------------------------------------------
`default_nettype none

package qte_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int ATAN_ENTRIES   = 24;
    localparam int WORK_FRAC      = 30;
    localparam int WORK_W         = 34;  // q30 terms doubled, with sign
    localparam int PROD_W         = 32;  // one q30 product
    localparam int CORDIC_W       = 38;  // cordic x/y with gain headroom
    localparam int NSTAGE         = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS
                                                                  : ATAN_ENTRIES;
    localparam int ISQ_STAGES     = WORK_FRAC + 1;
    localparam int ISQ_W          = 2 * WORK_FRAC + 2;
    localparam int CORDIC_LAT     = NSTAGE + 1;
    localparam int SQ_IDX         = 1 + ISQ_STAGES;
    localparam int PITCH_IDX      = SQ_IDX + CORDIC_LAT;
    localparam int Q_DEPTH        = 4;
    localparam int Q_AW           = $clog2(Q_DEPTH);

    localparam logic [15:0] PITCH_POS = 16'h4000;
    localparam logic [15:0] PITCH_NEG = 16'hC000;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [31:0] ANG_THREE_Q = 32'hC000_0000;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] quat_x;
        logic signed [COMPONENT_BITS-1:0] quat_y;
        logic signed [COMPONENT_BITS-1:0] quat_z;
        logic signed [COMPONENT_BITS-1:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic signed [15:0] roll_angle;
        logic               pitch_clamped;
    } t_result;

    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
    } t_prod;

    typedef struct packed {
        logic signed [WORK_W-1:0]    sp;
        logic [WORK_FRAC-1:0]        sq;
        logic                        clamp_pos;
        logic                        clamp_neg;
        logic signed [WORK_W-1:0]    yaw_y;
        logic signed [WORK_W-1:0]    yaw_x;
        logic signed [WORK_W-1:0]    roll_y;
        logic signed [WORK_W-1:0]    roll_x;
    } t_work;

    // component product to q30
    function automatic logic signed [PROD_W-1:0] to_work(
        logic signed [2*COMPONENT_BITS-1:0] p);
        localparam int PF  = 2 * (COMPONENT_BITS - 1);
        localparam int SHR = (PF >= WORK_FRAC) ? PF - WORK_FRAC : 0;
        localparam int SHL = (PF < WORK_FRAC) ? WORK_FRAC - PF : 0;
        logic signed [63:0] e;
        e = 64'(p);
        e = (e >>> SHR) <<< SHL;
        return e[PROD_W-1:0];
    endfunction

    // atan(2^-i), 2^32 units per turn
    function automatic logic [31:0] atan_entry(logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ src/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front: input products and term sums
// forms the nine q30 products, then the pitch sine and atan2 arguments
// ----------------------------------------------------------------------------
`default_nettype none

module qte_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire qte_pkg::t_quat i_quat,
    output logic                o_valid,
    output qte_pkg::t_work      o_work
);

    localparam int WW = qte_pkg::WORK_W;

    logic           r_v1, r_v2;
    qte_pkg::t_prod r_p;
    qte_pkg::t_work r_w;
    qte_pkg::t_work n_w;

    logic signed [WW-1:0] one_w;
    logic signed [WW-1:0] abs_sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p.xx <= qte_pkg::to_work(i_quat.quat_x * i_quat.quat_x);
        r_p.yy <= qte_pkg::to_work(i_quat.quat_y * i_quat.quat_y);
        r_p.zz <= qte_pkg::to_work(i_quat.quat_z * i_quat.quat_z);
        r_p.xy <= qte_pkg::to_work(i_quat.quat_x * i_quat.quat_y);
        r_p.xz <= qte_pkg::to_work(i_quat.quat_x * i_quat.quat_z);
        r_p.yz <= qte_pkg::to_work(i_quat.quat_y * i_quat.quat_z);
        r_p.wx <= qte_pkg::to_work(i_quat.quat_w * i_quat.quat_x);
        r_p.wy <= qte_pkg::to_work(i_quat.quat_w * i_quat.quat_y);
        r_p.wz <= qte_pkg::to_work(i_quat.quat_w * i_quat.quat_z);
        r_w    <= n_w;
    end

    always_comb begin
        one_w      = WW'(1) <<< qte_pkg::WORK_FRAC;
        n_w.sp     = (WW'(r_p.wx) - WW'(r_p.yz)) <<< 1;
        n_w.yaw_y  = (WW'(r_p.xz) + WW'(r_p.wy)) <<< 1;
        n_w.yaw_x  = one_w - ((WW'(r_p.xx) + WW'(r_p.yy)) <<< 1);
        n_w.roll_y = (WW'(r_p.xy) + WW'(r_p.wz)) <<< 1;
        n_w.roll_x = one_w - ((WW'(r_p.xx) + WW'(r_p.zz)) <<< 1);
        n_w.clamp_pos = (n_w.sp >= one_w);
        n_w.clamp_neg = (n_w.sp <= -one_w);
        abs_sp     = n_w.sp[WW-1] ? -n_w.sp : n_w.sp;
        // magnitude is below one whenever it is used
        n_w.sq     = abs_sp[qte_pkg::WORK_FRAC-1:0];
    end

    assign o_valid = r_v2;
    assign o_work  = r_w;

endmodule

`default_nettype wire

@@ src/qte_fifo.sv @@
// ----------------------------------------------------------------------------
// qte_fifo: short queue between front and back
// register-based, one push and one pop per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qte_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire qte_pkg::t_work i_data,
    input  wire logic           i_pop,
    output qte_pkg::t_work      o_data,
    output logic                o_empty,
    output logic [qte_pkg::Q_AW:0] o_count
);

    localparam int AW = qte_pkg::Q_AW;

    qte_pkg::t_work r_mem [0:qte_pkg::Q_DEPTH-1];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_count;
    logic           do_pop;

    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_count <= r_count + (AW+1)'(i_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ src/qte_isqrt.sv @@
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// one result bit per stage, floor of the square root
// ----------------------------------------------------------------------------
`default_nettype none

module qte_isqrt (
    input  wire logic                          i_clk,
    input  wire logic [2*qte_pkg::WORK_FRAC:0] i_v,
    output logic [qte_pkg::WORK_FRAC:0]        o_root
);

    localparam int N  = qte_pkg::ISQ_STAGES;
    localparam int SW = qte_pkg::ISQ_W;

    logic [SW-1:0] r_v   [1:N-1];
    logic [SW-1:0] r_res [1:N];

    for (genvar j = 0; j < N; j++) begin : g_stage
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - 1 - j));
        logic [SW-1:0] src_v, src_r, trial;
        if (j == 0) begin : g_first
            assign src_v = SW'(i_v);
            assign src_r = '0;
        end else begin : g_next
            assign src_v = r_v[j];
            assign src_r = r_res[j];
        end
        assign trial = src_r + BIT;
        always_ff @(posedge i_clk) begin
            r_res[j+1] <= (src_v >= trial) ? (src_r >> 1) + BIT : (src_r >> 1);
        end
        if (j < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_v[j+1] <= (src_v >= trial) ? src_v - trial : src_v;
            end
        end
    end

    assign o_root = r_res[N][qte_pkg::WORK_FRAC:0];

endmodule

`default_nettype wire

@@ src/qte_cordic.sv @@
// ----------------------------------------------------------------------------
// qte_cordic: pipelined vectoring cordic atan2
// quadrant fold, one micro-rotation per stage, rounded 16-bit binary angle
// ----------------------------------------------------------------------------
`default_nettype none

module qte_cordic (
    input  wire logic                               i_clk,
    input  wire logic signed [qte_pkg::WORK_W-1:0]  i_y,
    input  wire logic signed [qte_pkg::WORK_W-1:0]  i_x,
    output logic signed [15:0]                      o_angle
);

    localparam int NS = qte_pkg::NSTAGE;
    localparam int CW = qte_pkg::CORDIC_W;

    logic signed [CW-1:0] r_x [0:NS-1];
    logic signed [CW-1:0] r_y [0:NS-1];
    logic [31:0]          r_z [0:NS];
    logic                 r_zero [0:NS];

    logic signed [CW-1:0] xe, ye, n_x, n_y;
    logic [31:0]          n_z;
    logic [31:0]          z_rnd;

    always_comb begin
        xe  = CW'(i_x);
        ye  = CW'(i_y);
        n_x = xe;
        n_y = ye;
        n_z = '0;
        if (xe < 0) begin
            if (ye >= 0) begin
                n_x = ye;
                n_y = -xe;
                n_z = qte_pkg::ANG_QUARTER;
            end else begin
                n_x = -ye;
                n_y = xe;
                n_z = qte_pkg::ANG_THREE_Q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
        r_zero[0] <= (i_x == '0) && (i_y == '0);
    end

    for (genvar i = 0; i < NS; i++) begin : g_rot
        localparam logic [31:0] ATN = qte_pkg::atan_entry(5'(i));
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            r_z[i+1]    <= (r_y[i] > 0) ? r_z[i] + ATN : r_z[i] - ATN;
        end
        if (i < NS - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                end
            end
        end
    end

    assign z_rnd   = r_z[NS] + 32'h0000_8000;
    assign o_angle = r_zero[NS] ? 16'sd0 : z_rnd[31:16];

endmodule

`default_nettype wire

@@ src/qte_back.sv @@
// ----------------------------------------------------------------------------
// qte_back: angle pipeline
// pitch through square root and cordic, yaw and roll cordics aligned to it
// ----------------------------------------------------------------------------
`default_nettype none

module qte_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire qte_pkg::t_work i_work,
    output logic                o_valid,
    output qte_pkg::t_result    o_result
);

    localparam int WF = qte_pkg::WORK_FRAC;
    localparam int WW = qte_pkg::WORK_W;
    localparam int SI = qte_pkg::SQ_IDX;
    localparam int PI = qte_pkg::PITCH_IDX;
    localparam int CL = qte_pkg::CORDIC_LAT;

    logic                 r_v    [0:PI];
    qte_pkg::t_work       r_b0;
    logic [2*WF-1:0]      r_sqsq;
    logic [2*WF:0]        r_rem;
    logic signed [WW-1:0] r_sp   [1:SI];
    logic [1:0]           r_cl   [1:PI];
    logic [31:0]          r_yr   [CL+1:PI];

    logic [WF:0]          root;
    logic signed [15:0]   pitch_a, yaw_a, roll_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PI; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= PI; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0   <= i_work;
        r_sqsq <= i_work.sq * i_work.sq;
        r_rem  <= ((2*WF+1)'(1) << (2*WF)) - (2*WF+1)'(r_sqsq);
        r_sp[1] <= r_b0.sp;
        for (int k = 2; k <= SI; k++) r_sp[k] <= r_sp[k-1];
        r_cl[1] <= {r_b0.clamp_pos, r_b0.clamp_neg};
        for (int k = 2; k <= PI; k++) r_cl[k] <= r_cl[k-1];
        r_yr[CL+1] <= {yaw_a, roll_a};
        for (int k = CL + 2; k <= PI; k++) r_yr[k] <= r_yr[k-1];
    end

    qte_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_v    (r_rem),
        .o_root (root)
    );

    qte_cordic u_pitch (
        .i_clk   (i_clk),
        .i_y     (r_sp[SI]),
        .i_x     (WW'(root)),
        .o_angle (pitch_a)
    );

    qte_cordic u_yaw (
        .i_clk   (i_clk),
        .i_y     (r_b0.yaw_y),
        .i_x     (r_b0.yaw_x),
        .o_angle (yaw_a)
    );

    qte_cordic u_roll (
        .i_clk   (i_clk),
        .i_y     (r_b0.roll_y),
        .i_x     (r_b0.roll_x),
        .o_angle (roll_a)
    );

    always_comb begin
        o_result.yaw_angle     = r_yr[PI][31:16];
        o_result.roll_angle    = r_yr[PI][15:0];
        o_result.pitch_clamped = r_cl[PI][1] | r_cl[PI][0];
        if (r_cl[PI][1]) begin
            o_result.pitch_angle = qte_pkg::PITCH_POS;
        end else if (r_cl[PI][0]) begin
            o_result.pitch_angle = qte_pkg::PITCH_NEG;
        end else begin
            o_result.pitch_angle = pitch_a;
        end
    end

    assign o_valid = r_v[PI];

endmodule

`default_nettype wire

@@ src/quaternion_to_euler_angles.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: attitude quaternion to yaw, pitch, roll
// q1.15 quaternion in, 16-bit binary angles out, y-x-z rotation order
// ----------------------------------------------------------------------------
// o_valid strobes for an accepted beat after the front, the queue, the back pipeline and the output register
// throughput: one beat per cycle while busy is low, no dependence between beats
// latency is set by the 31-stage square root chain feeding the 16-stage cordic
// the receiver cannot stall; results are never held back
// synchronous active-low reset clears the valid pipeline and the queue
`default_nettype none

module quaternion_to_euler_angles (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire qte_pkg::t_quat   i_quat,
    output logic                  o_valid,
    output qte_pkg::t_result      o_result
);

    logic                    accept;
    logic                    f_valid;
    qte_pkg::t_work          f_work;
    qte_pkg::t_work          q_data;
    logic                    q_empty;
    logic [qte_pkg::Q_AW:0]  q_count;
    logic                    b_valid;
    qte_pkg::t_result        b_result;
    logic                    r_valid;
    qte_pkg::t_result        r_result;

    // two beats may still be in the front stages, keep room for them
    assign busy   = (q_count >= (qte_pkg::Q_AW+1)'(qte_pkg::Q_DEPTH - 2));
    assign accept = start && !busy;

    // front: products and terms, classifies pitch saturation
    qte_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_quat  (i_quat),
        .o_valid (f_valid),
        .o_work  (f_work)
    );

    // queue decouples front and back
    qte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_work),
        .i_pop   (1'b1),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    // back drains the queue head every cycle
    qte_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_empty),
        .i_work   (q_data),
        .o_valid  (b_valid),
        .o_result (b_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= b_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire
